// File: src/cc_pkg.sv
// shared widths and sideband types for the circumcircle pipeline
// no dependencies; imported by every module of the block
package cc_pkg;

    // input coordinate width (signed fixed point, output keeps the same scale)
    localparam int CW    = 16;
    // coordinate differences
    localparam int DW    = CW + 1;
    // products of two differences
    localparam int PW    = 2 * DW;
    // sums of two squares
    localparam int AW    = PW + 1;
    // doubled determinant
    localparam int DETW  = AW + 1;
    // product of a difference and a sum of squares
    localparam int MW    = DW + AW;
    // cramer numerators
    localparam int NW    = MW + 1;
    // rounding numerator 2*num + |det|
    localparam int N2W   = NW + 2;
    // divider dividend magnitude and quotient width
    localparam int QW    = N2W - 1;
    // divisor 2*|det|
    localparam int D2W   = DETW;
    // signed centre offset
    localparam int QSW   = QW + 1;
    // output field width
    localparam int OW    = 32;
    // squared radius
    localparam int SW    = 2 * OW + 1;
    // square root width and its remainder
    localparam int RW    = (SW + 1) / 2;
    localparam int RREMW = RW + 2;

    // sideband that rides through the divider
    typedef struct packed {
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic                 negx;
        logic                 negy;
        logic                 coll;
    } t_div_side;

    // sideband that rides through the square root
    typedef struct packed {
        logic signed [OW-1:0] cx;
        logic signed [OW-1:0] cy;
        logic                 big;
        logic                 coll;
    } t_sq_side;

endpackage

// File: src/circumcircle_from_three_points_unit.sv
// top level of the circumcircle pipeline: front, divider, centre and radius stages, square root
// depends on cc_pkg, cc_front, cc_div, cc_sqrt
//
//   channel  direction  handshake            payload
//   points   in         i_valid / o_stall    i_first_x .. i_third_y, signed Q12.4
//   circle   out        o_valid / i_stall    o_center_x, o_center_y, o_radius, o_collinear
//
// one triple enters every cycle while the output register is not both full and stalled;
// the divider and the square root are bit-per-stage: one stage per quotient bit or root bit.
// synchronous active-low reset clears only the valid bits of every stage.
// the whole pipeline advances together; it holds only while the output register is
// full and stalled, so o_stall follows i_stall in that case and nothing is lost.
module circumcircle_from_three_points_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [cc_pkg::CW-1:0] i_first_x,
    input  logic signed [cc_pkg::CW-1:0] i_first_y,
    input  logic signed [cc_pkg::CW-1:0] i_second_x,
    input  logic signed [cc_pkg::CW-1:0] i_second_y,
    input  logic signed [cc_pkg::CW-1:0] i_third_x,
    input  logic signed [cc_pkg::CW-1:0] i_third_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [cc_pkg::OW-1:0] o_center_x,
    output logic signed [cc_pkg::OW-1:0] o_center_y,
    output logic [cc_pkg::OW-1:0]        o_radius,
    output logic                         o_collinear
);
    import cc_pkg::*;

    localparam logic signed [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic signed [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};

    function automatic logic signed [OW-1:0] sat_out(input logic signed [QSW:0] v);
        logic signed [QSW:0] hi;
        logic signed [QSW:0] lo;
        hi = (QSW+1)'(OUT_MAX);
        lo = (QSW+1)'(OUT_MIN);
        if (v > hi) begin
            return OUT_MAX;
        end else if (v < lo) begin
            return OUT_MIN;
        end
        return v[OW-1:0];
    endfunction

    logic                en;
    logic                f_valid;
    logic [QW-1:0]       f_nx, f_ny;
    logic [D2W-1:0]      f_d;
    t_div_side           f_side;
    logic                d_valid;
    logic [QW-1:0]       d_qx, d_qy;
    logic                d_rx_nz, d_ry_nz;
    t_div_side           d_side;
    logic                s_valid;
    logic [RW-1:0]       s_root;
    logic [RREMW-1:0]    s_rem;
    t_sq_side            s_side;

    logic [3:0]          r_v;
    // centre offsets and magnitudes
    logic signed [QSW-1:0] r1_qx, r1_qy;
    logic [QSW-1:0]        r1_mx, r1_my;
    t_div_side             r1_side;
    // saturated centre, radius operands
    logic [OW-1:0]         r2_mx, r2_my;
    t_sq_side              r2_side;
    // squares
    logic [2*OW-1:0]       r3_sx, r3_sy;
    t_sq_side              r3_side;
    // squared radius
    logic [SW-1:0]         r4_s;
    t_sq_side              r4_side;
    // output register
    logic                  r_out_valid;
    logic signed [OW-1:0]  r_cx, r_cy;
    logic [OW-1:0]         r_rad;
    logic                  r_coll;

    logic [RW:0]           n_r;
    logic [OW-1:0]         n_rad;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    cc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_valid),
        .i_first_x  (i_first_x),
        .i_first_y  (i_first_y),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .i_third_x  (i_third_x),
        .i_third_y  (i_third_y),
        .o_valid    (f_valid),
        .o_nx       (f_nx),
        .o_ny       (f_ny),
        .o_d        (f_d),
        .o_side     (f_side)
    );

    cc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_nx    (f_nx),
        .i_ny    (f_ny),
        .i_d     (f_d),
        .i_side  (f_side),
        .o_valid (d_valid),
        .o_qx    (d_qx),
        .o_qy    (d_qy),
        .o_rx_nz (d_rx_nz),
        .o_ry_nz (d_ry_nz),
        .o_side  (d_side)
    );

    // valid bits of the middle stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[2:0], d_valid};
        end
    end

    // middle stages: floor correction, centre, radius operands
    always_ff @(posedge i_clk) begin
        if (en) begin
            // negative dividend: floor is -(q + 1) when a remainder is left
            r1_qx   <= d_side.negx ? -$signed({1'b0, d_qx}) - QSW'(d_rx_nz)
                                   : $signed({1'b0, d_qx});
            r1_qy   <= d_side.negy ? -$signed({1'b0, d_qy}) - QSW'(d_ry_nz)
                                   : $signed({1'b0, d_qy});
            r1_mx   <= d_side.negx ? QSW'(d_qx) + QSW'(d_rx_nz) : QSW'(d_qx);
            r1_my   <= d_side.negy ? QSW'(d_qy) + QSW'(d_ry_nz) : QSW'(d_qy);
            r1_side <= d_side;
            // centre back in absolute coordinates
            r2_side.cx   <= sat_out((QSW+1)'(r1_qx) + (QSW+1)'(r1_side.x1));
            r2_side.cy   <= sat_out((QSW+1)'(r1_qy) + (QSW+1)'(r1_side.y1));
            r2_side.big  <= (r1_mx[QSW-1:OW] != '0) || (r1_my[QSW-1:OW] != '0);
            r2_side.coll <= r1_side.coll;
            r2_mx        <= r1_mx[OW-1:0];
            r2_my        <= r1_my[OW-1:0];
            // squared offsets
            r3_sx   <= (2*OW)'(r2_mx) * (2*OW)'(r2_mx);
            r3_sy   <= (2*OW)'(r2_my) * (2*OW)'(r2_my);
            r3_side <= r2_side;
            // squared radius
            r4_s    <= SW'(r3_sx) + SW'(r3_sy);
            r4_side <= r3_side;
        end
    end

    cc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v[3]),
        .i_s     (r4_s),
        .i_side  (r4_side),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_rem   (s_rem),
        .o_side  (s_side)
    );

    // round the root to nearest and saturate
    always_comb begin
        n_r   = (RW+1)'(s_root) + (RW+1)'(s_rem > RREMW'(s_root));
        n_rad = (s_side.big || (n_r[RW:OW] != '0)) ? '1 : n_r[OW-1:0];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx   <= s_side.coll ? '0 : s_side.cx;
            r_cy   <= s_side.coll ? '0 : s_side.cy;
            r_rad  <= s_side.coll ? '0 : n_rad;
            r_coll <= s_side.coll;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_center_x  = r_cx;
    assign o_center_y  = r_cy;
    assign o_radius    = r_rad;
    assign o_collinear = r_coll;

endmodule

// File: src/cc_front.sv
// front stages: differences, products, determinant, cramer numerators, rounding setup
// depends on cc_pkg; feeds cc_div
module cc_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [cc_pkg::CW-1:0] i_first_x,
    input  logic signed [cc_pkg::CW-1:0] i_first_y,
    input  logic signed [cc_pkg::CW-1:0] i_second_x,
    input  logic signed [cc_pkg::CW-1:0] i_second_y,
    input  logic signed [cc_pkg::CW-1:0] i_third_x,
    input  logic signed [cc_pkg::CW-1:0] i_third_y,
    output logic                         o_valid,
    output logic [cc_pkg::QW-1:0]        o_nx,
    output logic [cc_pkg::QW-1:0]        o_ny,
    output logic [cc_pkg::D2W-1:0]       o_d,
    output cc_pkg::t_div_side            o_side
);
    import cc_pkg::*;

    logic [6:0] r_v;

    // stage 1
    logic signed [DW-1:0] r1_u, r1_v, r1_s, r1_t;
    logic signed [CW-1:0] r1_x1, r1_y1;
    // stage 2
    logic signed [PW-1:0] r2_uu, r2_vv, r2_ss, r2_tt, r2_ut, r2_vs;
    logic signed [DW-1:0] r2_u, r2_v, r2_s, r2_t;
    logic signed [CW-1:0] r2_x1, r2_y1;
    // stage 3
    logic signed [AW-1:0]   r3_a2, r3_b2;
    logic signed [DETW-1:0] r3_det;
    logic signed [DW-1:0]   r3_u, r3_v, r3_s, r3_t;
    logic signed [CW-1:0]   r3_x1, r3_y1;
    // stage 4
    logic signed [MW-1:0]   r4_ta2, r4_vb2, r4_ub2, r4_sa2;
    logic signed [DETW-1:0] r4_det;
    logic signed [CW-1:0]   r4_x1, r4_y1;
    // stage 5
    logic signed [NW-1:0]   r5_numx, r5_numy;
    logic [DETW-1:0]        r5_adet;
    logic                   r5_neg, r5_coll;
    logic signed [CW-1:0]   r5_x1, r5_y1;
    // stage 6
    logic signed [N2W-1:0]  r6_n2x, r6_n2y;
    logic [D2W-1:0]         r6_d;
    logic                   r6_coll;
    logic signed [CW-1:0]   r6_x1, r6_y1;
    // stage 7
    logic [QW-1:0]          r7_nx, r7_ny;
    logic [D2W-1:0]         r7_d;
    t_div_side              r7_side;

    logic signed [AW-1:0]  n3_dd;
    logic signed [NW-1:0]  n6_sx, n6_sy;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    assign n3_dd = AW'(r2_ut) - AW'(r2_vs);
    assign n6_sx = r5_neg ? -r5_numx : r5_numx;
    assign n6_sy = r5_neg ? -r5_numy : r5_numy;

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // offsets from the first point
            r1_u  <= DW'(i_second_x) - DW'(i_first_x);
            r1_v  <= DW'(i_second_y) - DW'(i_first_y);
            r1_s  <= DW'(i_third_x) - DW'(i_first_x);
            r1_t  <= DW'(i_third_y) - DW'(i_first_y);
            r1_x1 <= i_first_x;
            r1_y1 <= i_first_y;
            // pairwise products
            r2_uu <= PW'(r1_u) * PW'(r1_u);
            r2_vv <= PW'(r1_v) * PW'(r1_v);
            r2_ss <= PW'(r1_s) * PW'(r1_s);
            r2_tt <= PW'(r1_t) * PW'(r1_t);
            r2_ut <= PW'(r1_u) * PW'(r1_t);
            r2_vs <= PW'(r1_v) * PW'(r1_s);
            r2_u  <= r1_u;
            r2_v  <= r1_v;
            r2_s  <= r1_s;
            r2_t  <= r1_t;
            r2_x1 <= r1_x1;
            r2_y1 <= r1_y1;
            // squared lengths and doubled determinant
            r3_a2  <= AW'(r2_uu) + AW'(r2_vv);
            r3_b2  <= AW'(r2_ss) + AW'(r2_tt);
            r3_det <= $signed({n3_dd, 1'b0});
            r3_u   <= r2_u;
            r3_v   <= r2_v;
            r3_s   <= r2_s;
            r3_t   <= r2_t;
            r3_x1  <= r2_x1;
            r3_y1  <= r2_y1;
            // numerator products
            r4_ta2 <= MW'(r3_t) * MW'(r3_a2);
            r4_vb2 <= MW'(r3_v) * MW'(r3_b2);
            r4_ub2 <= MW'(r3_u) * MW'(r3_b2);
            r4_sa2 <= MW'(r3_s) * MW'(r3_a2);
            r4_det <= r3_det;
            r4_x1  <= r3_x1;
            r4_y1  <= r3_y1;
            // numerators, divisor sign and magnitude
            r5_numx <= NW'(r4_ta2) - NW'(r4_vb2);
            r5_numy <= NW'(r4_ub2) - NW'(r4_sa2);
            r5_neg  <= r4_det[DETW-1];
            r5_adet <= r4_det[DETW-1] ? DETW'(-r4_det) : DETW'(r4_det);
            r5_coll <= (r4_det == '0);
            r5_x1   <= r4_x1;
            r5_y1   <= r4_y1;
            // round to nearest: floor((2*num + den) / (2*den))
            r6_n2x  <= $signed({n6_sx, 1'b0}) + $signed({2'b00, r5_adet});
            r6_n2y  <= $signed({n6_sy, 1'b0}) + $signed({2'b00, r5_adet});
            r6_d    <= {r5_adet[DETW-2:0], 1'b0};
            r6_coll <= r5_coll;
            r6_x1   <= r5_x1;
            r6_y1   <= r5_y1;
            // dividend magnitudes
            r7_nx        <= r6_n2x[N2W-1] ? QW'(-r6_n2x) : QW'(r6_n2x);
            r7_ny        <= r6_n2y[N2W-1] ? QW'(-r6_n2y) : QW'(r6_n2y);
            r7_d         <= r6_d;
            r7_side.x1   <= r6_x1;
            r7_side.y1   <= r6_y1;
            r7_side.negx <= r6_n2x[N2W-1];
            r7_side.negy <= r6_n2y[N2W-1];
            r7_side.coll <= r6_coll;
        end
    end

    assign o_valid = r_v[6];
    assign o_nx    = r7_nx;
    assign o_ny    = r7_ny;
    assign o_d     = r7_d;
    assign o_side  = r7_side;

endmodule

// File: src/cc_div.sv
// pipelined restoring divider, one quotient bit per stage, two dividends over one divisor
// depends on cc_pkg
module cc_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [cc_pkg::QW-1:0]  i_nx,
    input  logic [cc_pkg::QW-1:0]  i_ny,
    input  logic [cc_pkg::D2W-1:0] i_d,
    input  cc_pkg::t_div_side      i_side,
    output logic                   o_valid,
    output logic [cc_pkg::QW-1:0]  o_qx,
    output logic [cc_pkg::QW-1:0]  o_qy,
    output logic                   o_rx_nz,
    output logic                   o_ry_nz,
    output cc_pkg::t_div_side      o_side
);
    import cc_pkg::*;

    logic [QW:0]    r_v;
    logic [D2W-1:0] r_rx   [0:QW];
    logic [D2W-1:0] r_ry   [0:QW];
    logic [QW-1:0]  r_nx   [0:QW];
    logic [QW-1:0]  r_ny   [0:QW];
    logic [D2W-1:0] r_d    [0:QW];
    t_div_side      r_side [0:QW];

    logic [D2W:0]   trx [0:QW-1];
    logic [D2W:0]   try_[0:QW-1];
    logic [D2W:0]   dfx [0:QW-1];
    logic [D2W:0]   dfy [0:QW-1];
    logic [D2W-1:0] n_rx [0:QW-1];
    logic [D2W-1:0] n_ry [0:QW-1];
    logic [QW-1:0]  n_nx [0:QW-1];
    logic [QW-1:0]  n_ny [0:QW-1];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-1:0], i_valid};
        end
    end

    // one shift and trial subtract per stage; quotient bits fill in behind the dividend
    always_comb begin
        for (int k = 0; k < QW; k++) begin
            trx[k]  = {r_rx[k], r_nx[k][QW-1]};
            try_[k] = {r_ry[k], r_ny[k][QW-1]};
            dfx[k]  = trx[k] - {1'b0, r_d[k]};
            dfy[k]  = try_[k] - {1'b0, r_d[k]};
            n_rx[k] = dfx[k][D2W] ? trx[k][D2W-1:0] : dfx[k][D2W-1:0];
            n_ry[k] = dfy[k][D2W] ? try_[k][D2W-1:0] : dfy[k][D2W-1:0];
            n_nx[k] = {r_nx[k][QW-2:0], ~dfx[k][D2W]};
            n_ny[k] = {r_ny[k][QW-2:0], ~dfy[k][D2W]};
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx[0]   <= '0;
            r_ry[0]   <= '0;
            r_nx[0]   <= i_nx;
            r_ny[0]   <= i_ny;
            r_d[0]    <= i_d;
            r_side[0] <= i_side;
            for (int k = 0; k < QW; k++) begin
                r_rx[k+1]   <= n_rx[k];
                r_ry[k+1]   <= n_ry[k];
                r_nx[k+1]   <= n_nx[k];
                r_ny[k+1]   <= n_ny[k];
                r_d[k+1]    <= r_d[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_qx    = r_nx[QW];
    assign o_qy    = r_ny[QW];
    assign o_rx_nz = (r_rx[QW] != '0);
    assign o_ry_nz = (r_ry[QW] != '0);
    assign o_side  = r_side[QW];

endmodule

// File: src/cc_sqrt.sv
// pipelined restoring square root, one root bit per stage, remainder kept for rounding
// depends on cc_pkg
module cc_sqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [cc_pkg::SW-1:0]    i_s,
    input  cc_pkg::t_sq_side         i_side,
    output logic                     o_valid,
    output logic [cc_pkg::RW-1:0]    o_root,
    output logic [cc_pkg::RREMW-1:0] o_rem,
    output cc_pkg::t_sq_side         o_side
);
    import cc_pkg::*;

    logic [RW:0]       r_v;
    logic [RREMW-1:0]  r_rem  [0:RW];
    logic [RW-1:0]     r_root [0:RW];
    logic [2*RW-1:0]   r_s    [0:RW];
    t_sq_side          r_side [0:RW];

    logic [RREMW+1:0]  tv   [0:RW-1];
    logic [RREMW+1:0]  df   [0:RW-1];
    logic [RREMW-1:0]  n_rem  [0:RW-1];
    logic [RW-1:0]     n_root [0:RW-1];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[RW-1:0], i_valid};
        end
    end

    // bring down two radicand bits, try 4*root + 1
    always_comb begin
        for (int k = 0; k < RW; k++) begin
            tv[k]     = {r_rem[k], r_s[k][2*RW-1 -: 2]};
            df[k]     = tv[k] - (RREMW+2)'({r_root[k], 2'b01});
            n_rem[k]  = df[k][RREMW+1] ? tv[k][RREMW-1:0] : df[k][RREMW-1:0];
            n_root[k] = {r_root[k][RW-2:0], ~df[k][RREMW+1]};
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_s[0]    <= (2*RW)'(i_s);
            r_side[0] <= i_side;
            for (int k = 0; k < RW; k++) begin
                r_rem[k+1]  <= n_rem[k];
                r_root[k+1] <= n_root[k];
                r_s[k+1]    <= {r_s[k][2*RW-3:0], 2'b00};
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[RW];
    assign o_root  = r_root[RW];
    assign o_rem   = r_rem[RW];
    assign o_side  = r_side[RW];

endmodule

// File: verif/tb.sv
// self-checking testbench for the circumcircle pipeline: random and directed point triples
// depends on cc_pkg and circumcircle_from_three_points_unit; predicts each circle in wide integers
`timescale 1ns / 1ps

module tb;

    localparam int LATENCY   = 7 + 55 + 4 + 34 + 1;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic signed [15:0] x1, y1, x2, y2, x3, y3;
    } t_triple;

    typedef struct {
        logic [31:0] cx, cy, rad;
        logic        coll;
    } t_circle;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [cc_pkg::CW-1:0] i_first_x = '0, i_first_y = '0, i_second_x = '0;
    logic signed [cc_pkg::CW-1:0] i_second_y = '0, i_third_x = '0, i_third_y = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [cc_pkg::OW-1:0] o_center_x, o_center_y;
    logic [cc_pkg::OW-1:0] o_radius;
    logic o_collinear;

    t_triple pending_triples[$];
    t_circle expected_circles[$];
    int fail_count = 0;
    int idle_cycles = 0;
    int hold_off = 0;
    int stall_wait = 0;
    bit stimulus_done = 1'b0;
    bit pause_req = 1'b0;

    circumcircle_from_three_points_unit uut (.*);

    always #6 i_clk = ~i_clk;

    // round num/den to nearest, ties toward plus infinity
    function automatic logic signed [127:0] round_div(logic signed [127:0] num,
                                                     logic signed [127:0] den);
        logic signed [127:0] n2, d2;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        n2 = 2 * num + den;
        d2 = 2 * den;
        if (n2 >= 0) return n2 / d2;
        return -((-n2 + d2 - 1) / d2);
    endfunction

    function automatic logic [31:0] sat_signed(logic signed [127:0] v);
        if (v < -128'sd2147483648) return 32'h8000_0000;
        if (v > 128'sd2147483647) return 32'h7FFF_FFFF;
        return v[31:0];
    endfunction

    function automatic logic [31:0] circle_radius(logic signed [127:0] qx,
                                                 logic signed [127:0] qy);
        logic [127:0] s, rr, lo, hi, mid;
        if (qx > 128'sd4294967295 || qx < -128'sd4294967295 ||
            qy > 128'sd4294967295 || qy < -128'sd4294967295)
            return 32'hFFFF_FFFF;
        s = qx * qx + qy * qy;
        lo = 0;
        hi = 128'd1 << 33;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (s < mid * mid) hi = mid;
            else lo = mid;
        end
        rr = s - lo * lo;
        if (lo < rr) lo = lo + 1;
        return (lo > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : lo[31:0];
    endfunction

    function automatic t_circle predict_circle(t_triple p);
        logic signed [127:0] x1, y1, u, v, s, t, a2, b2, det, qx, qy;
        t_circle c;
        x1 = p.x1; y1 = p.y1;
        u = p.x2 - x1; v = p.y2 - y1;
        s = p.x3 - x1; t = p.y3 - y1;
        a2 = u * u + v * v;
        b2 = s * s + t * t;
        det = 2 * (u * t - v * s);
        c = '{cx: '0, cy: '0, rad: '0, coll: 1'b1};
        if (det == 0) return c;
        qx = round_div(t * a2 - v * b2, det);
        qy = round_div(u * b2 - s * a2, det);
        c.cx = sat_signed(qx + x1);
        c.cy = sat_signed(qy + y1);
        c.rad = circle_radius(qx, qy);
        c.coll = 1'b0;
        return c;
    endfunction

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1: return $signed(16'($urandom_range(0, 64))) - 16'sd32;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_triple(input logic signed [15:0] a, b, c, d, e, f);
        pending_triples.insert(pending_triples.size(), t_triple'{a, b, c, d, e, f});
    endtask

    // stimulus: directed corners and small cases, then random triples with one all-zero triple midway
    initial begin
        t_triple p;
        add_triple(0, 0, 16, 0, 0, 16);
        add_triple(0, 0, 0, 0, 0, 0);
        add_triple(0, 0, 16, 16, 32, 32);
        add_triple(5, 5, 5, 5, 40, -7);
        add_triple(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000);
        add_triple(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        add_triple(0, 0, 1, 0, 16'sh7FFF, 1);
        add_triple(16'sh8000, 0, 16'sh7FFF, 1, 0, 16'sh7FFF);
        add_triple(0, 0, 1, 0, 0, 1);
        add_triple(-1, -1, 1, 0, 0, 1);
        add_triple(16'sh8000, 16'sh8000, 16'sh8001, 16'sh8000, 16'sh7FFF, 16'sh8001);
        add_triple(-16'sd3, 16'sd7, 16'sd9, -16'sd2, -16'sd11, 16'sd5);
        add_triple(16'shFFFF, 16'shFFFF, 16'sh5555, 16'shAAAA, 16'sh0001, 16'sh7FFE);
        for (int i = 0; i < 650; i++) begin
            p = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord()};
            if ($urandom_range(0, 15) == 0) begin
                p.x3 = p.x2 + (p.x2 - p.x1);
                p.y3 = p.y2 + (p.y2 - p.y1);
            end
            if (i == 300) add_triple(0, 0, 0, 0, 0, 0);
            pending_triples.insert(pending_triples.size(), p);
        end
    end

    // reset and end of run
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stimulus_done && expected_circles.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (fail_count == 0 && expected_circles.size() == 0)
            $display("circumcircle_from_three_points_unit test passed");
        else
            $display("circumcircle_from_three_points_unit test failed");
        $finish;
    end

    // driver: one triple per transfer, random gaps between triples, one drain pause midway
    always @(posedge i_clk) begin
        int gap;
        if (i_rst_n) begin
            gap = hold_off;
            if (i_valid && !o_stall) begin
                expected_circles.insert(expected_circles.size(),
                                        predict_circle(pending_triples.pop_front()));
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
                if (pending_triples.size() == 330) pause_req = 1'b1;
            end
            // payload may change only when not held by a stall
            if (!(i_valid && o_stall)) begin
                if (pending_triples.size() == 0) begin
                    i_valid <= 1'b0;
                    stimulus_done <= 1'b1;
                end else if (pause_req && expected_circles.size() != 0) begin
                    i_valid <= 1'b0;
                end else if (gap > 0) begin
                    gap = gap - 1;
                    i_valid <= 1'b0;
                end else begin
                    pause_req = 1'b0;
                    i_valid <= 1'b1;
                    {i_first_x, i_first_y} <= {pending_triples[0].x1, pending_triples[0].y1};
                    {i_second_x, i_second_y} <= {pending_triples[0].x2, pending_triples[0].y2};
                    {i_third_x, i_third_y} <= {pending_triples[0].x3, pending_triples[0].y3};
                end
            end
            hold_off = gap;
        end
    end

    // monitor: compare each result transfer with the oldest prediction; random stalls
    always @(posedge i_clk) begin
        t_circle e;
        int w;
        if (i_rst_n) begin
            w = stall_wait;
            if (o_valid && !i_stall) begin
                if (expected_circles.size() == 0) begin
                    $error("result with nothing expected");
                    fail_count++;
                end else begin
                    e = expected_circles.pop_front();
                    if (o_center_x !== e.cx) begin
                        $error("center_x expected %0h actual %0h", e.cx, o_center_x);
                        fail_count++;
                    end
                    if (o_center_y !== e.cy) begin
                        $error("center_y expected %0h actual %0h", e.cy, o_center_y);
                        fail_count++;
                    end
                    if (o_radius !== e.rad) begin
                        $error("radius expected %0h actual %0h", e.rad, o_radius);
                        fail_count++;
                    end
                    if (o_collinear !== e.coll) begin
                        $error("collinear expected %0b actual %0b", e.coll, o_collinear);
                        fail_count++;
                    end
                end
                w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            end
            // hold off the next result for the drawn number of cycles
            if (w > 0) begin
                stall_wait <= w - 1;
                i_stall <= 1'b1;
            end else begin
                stall_wait <= 0;
                i_stall <= 1'b0;
            end
            // watchdog on cycles without any transfer
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("circumcircle_from_three_points_unit test failed");
                $finish;
            end
        end
    end

endmodule
